// ----- hw/rtl/salc_pkg.sv -----
// Shared types and constants for the set-associative LRU cache tag store.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps
package salc_pkg;
   localparam int SETS       = 1024;
   localparam int SET_BITS   = 10;
   localparam int WAYS       = 4;
   localparam int WAY_BITS   = 2;
   localparam int FILL_BITS  = 3;
   localparam int AGE_BITS   = 32;
   localparam int TAG_WIDTH  = 64;
   localparam int ADDR_BITS  = 64;
   localparam int CNT_BITS   = 48;
   localparam int NUM_CNT    = 6;
   localparam int FIFO_DEPTH = 2;
   localparam int PTR_BITS   = 1;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
   localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [3:0] INDEX_LIMIT = 4'd10;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;

   localparam logic [1:0] KIND_HIT     = 2'd0;
   localparam logic [1:0] KIND_FILL    = 2'd1;
   localparam logic [1:0] KIND_REPLACE = 2'd2;
   localparam logic [1:0] KIND_NONE    = 2'd3;

   localparam int CNT_ACCESS      = 0;
   localparam int CNT_MISS        = 1;
   localparam int CNT_READ_ACCESS = 2;
   localparam int CNT_READ_MISS   = 3;
   localparam int CNT_WRITE_ACCESS = 4;
   localparam int CNT_WRITE_MISS  = 5;

   localparam logic CSR_OFFSET = 1'b0;
   localparam logic CSR_INDEX  = 1'b1;

   typedef struct packed {
      logic [1:0]           op;
      logic [SET_BITS-1:0]  set;
      logic [TAG_WIDTH-1:0] tag;
   } item_type;

   typedef struct packed {
      logic [FILL_BITS-1:0]           fill;
      logic [WAYS-1:0][TAG_WIDTH-1:0] tag;
      logic [WAYS-1:0][AGE_BITS-1:0]  age;
   } row_type;

   typedef struct packed {
      logic                              hit;
      logic [WAY_BITS-1:0]               way;
      logic [1:0]                        fill_kind;
      logic                              error;
      logic [NUM_CNT-1:0][CNT_BITS-1:0]  cnt;
   } result_type;

   typedef struct packed {
      logic clear_busy;
   } back_status_type;
endpackage

// ----- hw/rtl/salc_front.sv -----
// Front part: configuration registers, request acceptance and address split.
// Depends on salc_pkg.
`timescale 1ns / 1ps
module salc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [salc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [1:0]                           req_op,
   input  logic [salc_pkg::ADDR_BITS-1:0]       req_address,
   input  salc_pkg::back_status_type            status,
   input  logic                                 fifo_full,
   output logic                                 fifo_push,
   output salc_pkg::item_type                   fifo_item
);
   import salc_pkg::*;

   logic [4:0]           offset_bits_ff, offset_bits_in;
   logic [3:0]           index_bits_ff, index_bits_in;
   logic [3:0]           ib;
   logic [ADDR_BITS-1:0] blk;
   logic [SET_BITS-1:0]  set_mask;

   always_comb begin
      offset_bits_in = offset_bits_ff;
      index_bits_in  = index_bits_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            CSR_OFFSET: offset_bits_in = csr_pwdata[4:0];
            CSR_INDEX:  index_bits_in  = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= 5'd6;
         index_bits_ff  <= 4'd10;
      end else begin
         offset_bits_ff <= offset_bits_in;
         index_bits_ff  <= index_bits_in;
      end
   end

   assign csr_prdata = csr_paddr[2] ? {28'd0, index_bits_ff} : {27'd0, offset_bits_ff};

   // Index width is clamped to the number of set bits the store has.
   assign ib       = (index_bits_ff > INDEX_LIMIT) ? INDEX_LIMIT : index_bits_ff;
   assign blk      = req_address >> offset_bits_ff;
   assign set_mask = (SET_BITS'(1) << ib) - SET_BITS'(1);

   assign req_tready     = !fifo_full && !status.clear_busy;
   assign fifo_push      = req_tvalid && req_tready;
   assign fifo_item.op   = req_op;
   assign fifo_item.set  = blk[SET_BITS-1:0] & set_mask;
   assign fifo_item.tag  = blk >> ib;
endmodule

// ----- hw/rtl/salc_fifo.sv -----
// Two-entry queue that decouples the front part from the back part.
// Depends on salc_pkg.
`timescale 1ns / 1ps
module salc_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  salc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output salc_pkg::item_type pop_item,
   output logic               empty
);
   import salc_pkg::*;

   item_type            slot_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]   count_ff;

   assign full     = (count_ff == (PTR_BITS+1)'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
      end
   end
endmodule

// ----- hw/rtl/salc_back.sv -----
// Back part: set memory, tag compare, LRU update, event counters, result register.
// Depends on salc_pkg.
`timescale 1ns / 1ps
module salc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fifo_empty,
   input  salc_pkg::item_type         fifo_item,
   output logic                       fifo_pop,
   output salc_pkg::back_status_type  status,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output salc_pkg::result_type       rsp_result
);
   import salc_pkg::*;

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOKUP} state_type;

   state_type           state_ff;
   logic [SET_BITS:0]   clr_cnt_ff;
   item_type            item_ff;
   row_type             rd_row_ff;
   row_type             mem [SETS];
   row_type             wr_row;
   logic                mem_we;
   logic [SET_BITS-1:0] mem_waddr;
   logic                rsp_valid_ff;
   result_type          rsp_ff;
   result_type          res_in;
   row_type             new_row;
   logic [NUM_CNT-1:0][CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                slot_free;
   logic                do_done;

   logic [WAYS-1:0]                valid;
   logic [WAYS-1:0][AGE_BITS-1:0]  aged;
   logic                           hit;
   logic [WAY_BITS-1:0]            hit_way;
   logic [WAY_BITS-1:0]            old_way;
   logic [AGE_BITS-1:0]            old_age;
   logic                           op_ok;
   logic                           is_read;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign fifo_pop  = (state_ff == S_IDLE) && !fifo_empty;
   assign do_done   = (state_ff == S_LOOKUP) && slot_free;
   assign status.clear_busy = (state_ff == S_CLEAR);

   // Ways fill from the lowest index and are never invalidated, so the
   // valid ways of a set are exactly those below its fill count.
   always_comb begin
      op_ok   = (item_ff.op == OP_READ) || (item_ff.op == OP_WRITE);
      is_read = (item_ff.op == OP_READ);
      hit     = 1'b0;
      hit_way = '0;
      for (int i = 0; i < WAYS; i++) begin
         valid[i] = (FILL_BITS'(i) < rd_row_ff.fill);
         aged[i]  = (valid[i] && rd_row_ff.age[i] != AGE_MAX) ?
                    rd_row_ff.age[i] + 1'b1 : rd_row_ff.age[i];
      end
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (valid[i] && rd_row_ff.tag[i] == item_ff.tag) begin
            hit     = 1'b1;
            hit_way = WAY_BITS'(i);
         end
      end
      old_way = '0;
      old_age = aged[0];
      for (int i = 1; i < WAYS; i++) begin
         if (aged[i] > old_age) begin
            old_age = aged[i];
            old_way = WAY_BITS'(i);
         end
      end

      new_row     = rd_row_ff;
      new_row.age = aged;
      cnt_in      = cnt_ff;
      res_in.hit       = 1'b0;
      res_in.way       = '0;
      res_in.fill_kind = KIND_NONE;
      res_in.error     = !op_ok;
      if (op_ok) begin
         cnt_in[CNT_ACCESS] = (cnt_ff[CNT_ACCESS] != CNT_MAX) ?
                              cnt_ff[CNT_ACCESS] + 1'b1 : cnt_ff[CNT_ACCESS];
         if (is_read) begin
            cnt_in[CNT_READ_ACCESS] = (cnt_ff[CNT_READ_ACCESS] != CNT_MAX) ?
               cnt_ff[CNT_READ_ACCESS] + 1'b1 : cnt_ff[CNT_READ_ACCESS];
         end else begin
            cnt_in[CNT_WRITE_ACCESS] = (cnt_ff[CNT_WRITE_ACCESS] != CNT_MAX) ?
               cnt_ff[CNT_WRITE_ACCESS] + 1'b1 : cnt_ff[CNT_WRITE_ACCESS];
         end
         if (hit) begin
            res_in.hit            = 1'b1;
            res_in.way            = hit_way;
            res_in.fill_kind      = KIND_HIT;
            new_row.age[hit_way]  = '0;
         end else begin
            cnt_in[CNT_MISS] = (cnt_ff[CNT_MISS] != CNT_MAX) ?
                               cnt_ff[CNT_MISS] + 1'b1 : cnt_ff[CNT_MISS];
            if (is_read) begin
               cnt_in[CNT_READ_MISS] = (cnt_ff[CNT_READ_MISS] != CNT_MAX) ?
                  cnt_ff[CNT_READ_MISS] + 1'b1 : cnt_ff[CNT_READ_MISS];
            end else begin
               cnt_in[CNT_WRITE_MISS] = (cnt_ff[CNT_WRITE_MISS] != CNT_MAX) ?
                  cnt_ff[CNT_WRITE_MISS] + 1'b1 : cnt_ff[CNT_WRITE_MISS];
            end
            if (rd_row_ff.fill < FILL_BITS'(WAYS)) begin
               res_in.way       = rd_row_ff.fill[WAY_BITS-1:0];
               res_in.fill_kind = KIND_FILL;
               new_row.fill     = rd_row_ff.fill + 1'b1;
            end else begin
               res_in.way       = old_way;
               res_in.fill_kind = KIND_REPLACE;
            end
            new_row.tag[res_in.way] = item_ff.tag;
            new_row.age[res_in.way] = '0;
         end
      end
      res_in.cnt = cnt_in;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = item_ff.set;
      wr_row    = new_row;
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff[SET_BITS-1:0];
         wr_row    = rd_row_ff;
         wr_row.fill = '0;
      end else if (do_done) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= wr_row;
      if (fifo_pop) rd_row_ff <= mem[fifo_item.set];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         // A finished lookup loads the result; otherwise it stays until taken.
         rsp_valid_ff <= do_done || (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == (SET_BITS+1)'(SETS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (fifo_pop) state_ff <= S_LOOKUP;
            end
            S_LOOKUP: begin
               if (slot_free) begin
                  cnt_ff       <= cnt_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_pop) item_ff <= fifo_item;
      if (do_done)  rsp_ff  <= res_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;
endmodule

// ----- hw/rtl/set_assoc_lru_cache_tags.sv -----
// Top level of the set-associative LRU cache tag store.
// Depends on salc_pkg, salc_front, salc_fifo and salc_back.
`timescale 1ns / 1ps
//
//   Channel   Direction  Handshake          Carries
//   req_      in         tvalid/tready      one access: operation, address
//   rsp_      out        tvalid/tready      one result per access
//   csr_      in         APB psel/penable   offset_bits (0x0), index_bits (0x4)
//
// In the back part each access first reads the set's row from the synchronous
// set memory, then compares tags, updates ages and writes
// the row back. The front part splits the address as the request is accepted
// and a two-entry queue holds requests while the back part is busy.
// After reset a clearing pass zeroes the fill count of every
// set; no request is accepted during it, but configuration writes are taken.
// A result waits in the output register while rsp_tready is low; the back
// part then holds its finished lookup and the queue keeps accepting requests
// until it is full.
module set_assoc_lru_cache_tags (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // address [63:0]
   input  logic [1:0]   req_tuser,   // operation [1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // way [1:0], access_count [49:2], miss_count [97:50],
   // read_access_count [145:98], read_miss_count [193:146],
   // write_access_count [241:194], write_miss_count [289:242], zero fill above
   output logic [295:0] rsp_tdata,
   output logic [3:0]   rsp_tuser    // hit [0], fill_kind [2:1], error [3]
);
   import salc_pkg::*;

   back_status_type status;
   logic            fifo_full, fifo_empty, fifo_push, fifo_pop;
   item_type        push_item, pop_item;
   result_type      result;

   assign csr_pready = 1'b1;

   salc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_op      (req_tuser),
      .req_address (req_tdata),
      .status      (status),
      .fifo_full   (fifo_full),
      .fifo_push   (fifo_push),
      .fifo_item   (push_item)
   );

   salc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_item (push_item),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_item  (pop_item),
      .empty     (fifo_empty)
   );

   salc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_item  (pop_item),
      .fifo_pop   (fifo_pop),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // Counters go out lowest index first: access, miss, read access,
   // read miss, write access, write miss.
   assign rsp_tdata = {6'd0,
                       result.cnt[CNT_WRITE_MISS], result.cnt[CNT_WRITE_ACCESS],
                       result.cnt[CNT_READ_MISS], result.cnt[CNT_READ_ACCESS],
                       result.cnt[CNT_MISS], result.cnt[CNT_ACCESS],
                       result.way};
   assign rsp_tuser = {result.error, result.fill_kind, result.hit};
endmodule

// ----- hw/rtl/salc_checker.sv -----
// Port-level checks for the cache tag store, bound to the top level.
// Depends on set_assoc_lru_cache_tags.
`timescale 1ns / 1ps
module salc_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [295:0] rsp_tdata,
   input logic [3:0]   rsp_tuser
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_error_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[2:1] == 2'd3 && !rsp_tuser[0])
      else $error("invalid command reported an action");

   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[3] |-> (rsp_tuser[0] == (rsp_tuser[2:1] == 2'd0)))
      else $error("hit flag disagrees with fill kind");

   a_miss_le_access: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[97:50] <= rsp_tdata[49:2])
      else $error("miss count exceeds access count");
endmodule

bind set_assoc_lru_cache_tags salc_checker u_salc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
